// ----- rtl/smxu_pkg.sv -----
// Shared types, opcode constants and helpers for the vector move and XOR unit.
package smxu_pkg;

    // Size of the vector register file.
    localparam int NUM_VECTOR_REGS = 16;
    localparam int REG_AW = (NUM_VECTOR_REGS > 1) ? $clog2(NUM_VECTOR_REGS) : 1;

    // Opcode bytes of the 0F two-byte map that the unit executes.
    localparam logic [7:0] OP_XORPS     = 8'h57;
    localparam logic [7:0] OP_PXOR      = 8'hEF;
    localparam logic [7:0] OP_MOVAPS_LD = 8'h28;
    localparam logic [7:0] OP_MOVAPS_ST = 8'h29;
    localparam logic [7:0] OP_MOVUPS_LD = 8'h10;
    localparam logic [7:0] OP_MOVUPS_ST = 8'h11;
    localparam logic [7:0] OP_MOVDQ_LD  = 8'h6F;
    localparam logic [7:0] OP_MOVDQ_ST  = 8'h7F;

    // Low address bits that must be zero for the aligned forms.
    localparam logic [3:0] ALIGN_MASK = 4'hF;

    typedef logic [REG_AW-1:0] t_vaddr;
    typedef logic [127:0]      t_vec;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNIMPL    = 2'd1,
        ST_UNALIGNED = 2'd2,
        ST_FAULT     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_NONE,
        K_XOR,
        K_LOAD,
        K_STORE
    } t_kind;

    // One input item as it arrives on the ports.
    typedef struct packed {
        logic        two_byte_map;
        logic [7:0]  opcode;
        logic        prefix_opsize;
        logic        prefix_rep;
        logic        prefix_repne;
        logic [3:0]  reg_index;
        logic [3:0]  rm_index;
        logic        rm_is_register;
        logic [3:0]  address_low;
        logic [63:0] load_low;
        logic [63:0] load_high;
        logic        memory_fault;
    } t_item;

    // A classified item waiting for the back end.
    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic        is_reg;
        logic [3:0]  reg_idx;
        logic [3:0]  rm_idx;
        logic [63:0] load_low;
        logic [63:0] load_high;
    } t_uop;

    typedef struct packed {
        logic valid;
        t_uop uop;
    } t_issue;

    typedef struct packed {
        t_status     status;
        logic        store_valid;
        logic [63:0] store_low;
        logic [63:0] store_high;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_push;

    // True when a register index names an existing register.
    function automatic logic in_range(input logic [3:0] idx);
        return 32'(idx) < NUM_VECTOR_REGS;
    endfunction

    // Register file address of a register index.
    function automatic t_vaddr to_addr(input logic [3:0] idx);
        return REG_AW'(idx);
    endfunction

endpackage

// ----- rtl/smxu_front.sv -----
// Front end: classifies incoming items and holds them in a two-entry issue queue.
module smxu_front
    import smxu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_item  i_item,
    output t_issue o_issue,
    input  logic   i_pop
);

    t_uop       w_uop;
    logic       w_aligned;
    logic       w_noprefix;
    logic       w_push_ok;
    logic       w_pop_ok;

    t_uop       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    // Decode the opcode and prefixes into an operation kind and a status.
    always_comb begin
        w_uop           = '0;
        w_uop.kind      = K_NONE;
        w_uop.is_reg    = i_item.rm_is_register;
        w_uop.reg_idx   = i_item.reg_index;
        w_uop.rm_idx    = i_item.rm_index;
        w_uop.load_low  = i_item.load_low;
        w_uop.load_high = i_item.load_high;
        w_aligned       = 1'b0;
        w_noprefix      = !i_item.prefix_opsize && !i_item.prefix_rep && !i_item.prefix_repne;
        if (i_item.two_byte_map) begin
            if (i_item.opcode == OP_XORPS ||
                (i_item.opcode == OP_PXOR && i_item.prefix_opsize)) begin
                w_uop.kind = K_XOR;
            end else if (i_item.opcode == OP_MOVAPS_LD || i_item.opcode == OP_MOVAPS_ST) begin
                w_uop.kind = (i_item.opcode == OP_MOVAPS_LD) ? K_LOAD : K_STORE;
                w_aligned  = 1'b1;
            end else if ((i_item.opcode == OP_MOVUPS_LD || i_item.opcode == OP_MOVUPS_ST) &&
                         w_noprefix) begin
                w_uop.kind = (i_item.opcode == OP_MOVUPS_LD) ? K_LOAD : K_STORE;
            end else if ((i_item.opcode == OP_MOVDQ_LD || i_item.opcode == OP_MOVDQ_ST) &&
                         (i_item.prefix_opsize || i_item.prefix_rep)) begin
                w_uop.kind = (i_item.opcode == OP_MOVDQ_LD) ? K_LOAD : K_STORE;
                w_aligned  = i_item.prefix_opsize;
            end
        end
        // Alignment is checked before the memory fault flag.
        if (w_uop.kind == K_NONE) begin
            w_uop.status = ST_UNIMPL;
        end else if (!i_item.rm_is_register && w_aligned &&
                     (i_item.address_low & ALIGN_MASK) != 4'd0) begin
            w_uop.status = ST_UNALIGNED;
        end else if (!i_item.rm_is_register && i_item.memory_fault) begin
            w_uop.status = ST_FAULT;
        end else begin
            w_uop.status = ST_OK;
        end
    end

    assign o_full    = (r_cnt == 2'd2);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wp <= !r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= !r_rp;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_uop;
        end
    end

    assign o_issue.valid = (r_cnt != 2'd0);
    assign o_issue.uop   = r_q[r_rp];

endmodule

// ----- rtl/smxu_back.sv -----
// Back end: register file read stage and execute stage with write forwarding.
module smxu_back
    import smxu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_issue    i_issue,
    output logic      o_pop,
    input  logic      i_space,
    output t_res_push o_push
);

    t_vec   r_mem [NUM_VECTOR_REGS];
    logic   r_vld [NUM_VECTOR_REGS];

    logic   r_x_valid;
    t_uop   r_x_uop;
    t_vec   r_mem_a;
    t_vec   r_mem_b;
    logic   r_zero_a;
    logic   r_zero_b;
    logic   r_byp_a;
    logic   r_byp_b;
    t_vec   r_fwd;

    logic   w_adv;
    logic   w_retire;
    logic   w_ok;
    logic   w_we;
    logic   [3:0] w_widx;
    t_vec   w_wdata;
    t_vec   w_a;
    t_vec   w_b;
    t_vec   w_rm;
    t_vaddr w_ra;
    t_vaddr w_rb;
    logic   w_zero_a;
    logic   w_zero_b;

    assign w_retire = r_x_valid && i_space;
    assign w_adv    = i_issue.valid && (!r_x_valid || w_retire);
    assign o_pop    = w_adv;

    // Operands of the item in the execute stage, newest write first.
    assign w_a  = r_byp_a ? r_fwd : (r_zero_a ? '0 : r_mem_a);
    assign w_rm = r_byp_b ? r_fwd : (r_zero_b ? '0 : r_mem_b);
    assign w_b  = r_x_uop.is_reg ? w_rm : {r_x_uop.load_high, r_x_uop.load_low};
    assign w_ok = (r_x_uop.status == ST_OK);

    // Register write of the retiring item.
    always_comb begin
        w_we    = 1'b0;
        w_widx  = r_x_uop.reg_idx;
        w_wdata = w_b;
        case (r_x_uop.kind)
            K_XOR: begin
                w_we    = w_ok;
                w_wdata = w_a ^ w_b;
            end
            K_LOAD: begin
                w_we = w_ok;
            end
            K_STORE: begin
                w_we    = w_ok && r_x_uop.is_reg;
                w_widx  = r_x_uop.rm_idx;
                w_wdata = w_a;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        w_we = w_we && w_retire && in_range(w_widx);
    end

    // Result of the retiring item; store data is zero unless a store issues.
    always_comb begin
        o_push.valid       = w_retire;
        o_push.res.status  = r_x_uop.status;
        o_push.res.store_valid = w_ok && (r_x_uop.kind == K_STORE) && !r_x_uop.is_reg;
        o_push.res.store_low   = o_push.res.store_valid ? w_a[63:0]   : 64'd0;
        o_push.res.store_high  = o_push.res.store_valid ? w_a[127:64] : 64'd0;
    end

    // Read side flags; a register never written or out of range reads as zero.
    assign w_ra     = to_addr(i_issue.uop.reg_idx);
    assign w_rb     = to_addr(i_issue.uop.rm_idx);
    assign w_zero_a = !in_range(i_issue.uop.reg_idx) || !r_vld[w_ra];
    assign w_zero_b = !in_range(i_issue.uop.rm_idx) || !r_vld[w_rb];

    // Execute stage control and written-entry flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            for (int i = 0; i < NUM_VECTOR_REGS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (w_adv) begin
                r_x_valid <= 1'b1;
            end else if (w_retire) begin
                r_x_valid <= 1'b0;
            end
            if (w_we) begin
                r_vld[to_addr(w_widx)] <= 1'b1;
            end
        end
    end

    // Execute stage payload and forwarding of a write made at the read edge.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x_uop  <= i_issue.uop;
            r_zero_a <= w_zero_a;
            r_zero_b <= w_zero_b;
            r_byp_a  <= w_we && (w_widx == i_issue.uop.reg_idx);
            r_byp_b  <= w_we && (w_widx == i_issue.uop.rm_idx);
            r_fwd    <= w_wdata;
        end
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[to_addr(w_widx)] <= w_wdata;
        end
        if (w_adv) begin
            r_mem_a <= r_mem[w_ra];
            r_mem_b <= r_mem[w_rb];
        end
    end

endmodule

// ----- rtl/smxu_out_queue.sv -----
// Two-entry result queue that decouples the execute stage from the consumer.
module smxu_out_queue
    import smxu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_push,
    output logic      o_space,
    output logic      o_empty,
    input  logic      i_pop,
    output t_result   o_head
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push_ok;
    logic       w_pop_ok;

    assign o_space   = (r_cnt != 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign w_push_ok = i_push.valid && o_space;
    assign w_pop_ok  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push_ok && w_pop_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (w_push_ok) begin
                r_wp <= !r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= !r_rp;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= i_push.res;
        end
    end

    assign o_head = r_q[r_rp];

endmodule

// ----- rtl/sse_move_xor_unit.sv -----
// Top level of the vector move and XOR unit: front end, back end and result queue.

// The unit takes one decoded instruction item per cycle while not full and returns
// one result item for each, in order, sustaining one item per cycle when the
// consumer pops every cycle. An accepted item is classified and queued in the front
// end, reads the 16 x 128-bit register file into the execute stage registers,
// executes and writes the register file as it retires into the result queue, from
// whose head its result can be popped. The register file has a single write port and
// two registered read ports; a write is forwarded to the item reading behind it,
// so dependent items also run back to back. The register file needs no clearing
// pass after reset: per-register written flags make unwritten registers read as
// zero. Faulting, unaligned and unimplemented items change no register.
module sse_move_xor_unit
    import smxu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_two_byte_map,
    input  logic [7:0]  i_opcode,
    input  logic        i_prefix_opsize,
    input  logic        i_prefix_rep,
    input  logic        i_prefix_repne,
    input  logic [3:0]  i_reg_index,
    input  logic [3:0]  i_rm_index,
    input  logic        i_rm_is_register,
    input  logic [3:0]  i_address_low,
    input  logic [63:0] i_load_low,
    input  logic [63:0] i_load_high,
    input  logic        i_memory_fault,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic        o_store_valid,
    output logic [63:0] o_store_low,
    output logic [63:0] o_store_high
);

    t_item     w_item;
    t_issue    w_issue;
    logic      w_issue_pop;
    t_res_push w_res;
    logic      w_space;
    t_result   w_head;

    // Gather the input fields into one item.
    assign w_item.two_byte_map   = i_two_byte_map;
    assign w_item.opcode         = i_opcode;
    assign w_item.prefix_opsize  = i_prefix_opsize;
    assign w_item.prefix_rep     = i_prefix_rep;
    assign w_item.prefix_repne   = i_prefix_repne;
    assign w_item.reg_index      = i_reg_index;
    assign w_item.rm_index       = i_rm_index;
    assign w_item.rm_is_register = i_rm_is_register;
    assign w_item.address_low    = i_address_low;
    assign w_item.load_low       = i_load_low;
    assign w_item.load_high      = i_load_high;
    assign w_item.memory_fault   = i_memory_fault;

    smxu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (w_item),
        .o_issue (w_issue),
        .i_pop   (w_issue_pop)
    );

    smxu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .o_pop   (w_issue_pop),
        .i_space (w_space),
        .o_push  (w_res)
    );

    smxu_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res),
        .o_space (w_space),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (w_head)
    );

    // Drive the result fields from the head of the queue.
    assign o_status      = w_head.status;
    assign o_store_valid = w_head.store_valid;
    assign o_store_low   = w_head.store_low;
    assign o_store_high  = w_head.store_high;

    // A store is only issued by an item that succeeded.
    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_store_valid) |-> (o_status == ST_OK))
        else $error("store issued by an item that did not succeed");

    // Store data is zero on every result that issues no store.
    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_store_valid) |-> (o_store_low == 64'd0 && o_store_high == 64'd0))
        else $error("store data present without a store");

    // The execute stage retires only into a result queue with room.
    a_retire_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> w_space)
        else $error("result retired into a full queue");

    // A pushed result is visible at the queue head on the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |=> !empty)
        else $error("retired result not visible");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the vector move and XOR unit.
module tb;
    import smxu_pkg::*;

    // Prefix sets in the order {66, F3, F2}.
    localparam logic [2:0] PFX_NONE = 3'b000;
    localparam logic [2:0] PFX_66   = 3'b100;
    localparam logic [2:0] PFX_F3   = 3'b010;
    localparam logic [2:0] PFX_F2   = 3'b001;
    localparam logic [2:0] PFX_ALL  = 3'b111;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_two_byte_map = 1'b0;
    logic [7:0]  i_opcode = '0;
    logic        i_prefix_opsize = 1'b0;
    logic        i_prefix_rep = 1'b0;
    logic        i_prefix_repne = 1'b0;
    logic [3:0]  i_reg_index = '0;
    logic [3:0]  i_rm_index = '0;
    logic        i_rm_is_register = 1'b0;
    logic [3:0]  i_address_low = '0;
    logic [63:0] i_load_low = '0;
    logic [63:0] i_load_high = '0;
    logic        i_memory_fault = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic        o_store_valid;
    logic [63:0] o_store_low;
    logic [63:0] o_store_high;

    // Architectural copy of the register file, kept as two 64-bit halves.
    logic [63:0] arch_lo [NUM_VECTOR_REGS];
    logic [63:0] arch_hi [NUM_VECTOR_REGS];

    // Results that accepted instructions are still owed, oldest first.
    t_result     retire_q [$];

    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          rx_stall = 0;
    int          quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned stores_seen = 0;
    int unsigned status_count [4] = '{0, 0, 0, 0};

    sse_move_xor_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_two_byte_map   (i_two_byte_map),
        .i_opcode         (i_opcode),
        .i_prefix_opsize  (i_prefix_opsize),
        .i_prefix_rep     (i_prefix_rep),
        .i_prefix_repne   (i_prefix_repne),
        .i_reg_index      (i_reg_index),
        .i_rm_index       (i_rm_index),
        .i_rm_is_register (i_rm_is_register),
        .i_address_low    (i_address_low),
        .i_load_low       (i_load_low),
        .i_load_high      (i_load_high),
        .i_memory_fault   (i_memory_fault),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_store_valid    (o_store_valid),
        .o_store_low      (o_store_low),
        .o_store_high     (o_store_high)
    );

    always #2 i_clk = ~i_clk;

    // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Register reads beyond the file give zero; writes beyond it are dropped.
    function automatic void read_vec(input logic [3:0] idx, output logic [63:0] lo,
                                     output logic [63:0] hi);
        if (int'(idx) < NUM_VECTOR_REGS) begin
            lo = arch_lo[idx];
            hi = arch_hi[idx];
        end else begin
            lo = '0;
            hi = '0;
        end
    endfunction

    function automatic void write_vec(input logic [3:0] idx, input logic [63:0] lo,
                                      input logic [63:0] hi);
        if (int'(idx) < NUM_VECTOR_REGS) begin
            arch_lo[idx] = lo;
            arch_hi[idx] = hi;
        end
    endfunction

    // Decode and execute one instruction against the register copy.
    function automatic t_result execute_instr(input t_item it);
        t_result     res;
        t_kind       kind;
        logic        aligned;
        logic        no_pfx;
        logic [63:0] a_lo, a_hi, b_lo, b_hi;
        res = '0;
        res.status = ST_OK;
        kind = K_NONE;
        aligned = 1'b0;
        no_pfx = !(it.prefix_opsize || it.prefix_rep || it.prefix_repne);
        if (it.two_byte_map) begin
            if (it.opcode == OP_XORPS || (it.opcode == OP_PXOR && it.prefix_opsize)) begin
                kind = K_XOR;
            end else if (it.opcode == OP_MOVAPS_LD || it.opcode == OP_MOVAPS_ST) begin
                kind = (it.opcode == OP_MOVAPS_LD) ? K_LOAD : K_STORE;
                aligned = 1'b1;
            end else if ((it.opcode == OP_MOVUPS_LD || it.opcode == OP_MOVUPS_ST)
                         && no_pfx) begin
                kind = (it.opcode == OP_MOVUPS_LD) ? K_LOAD : K_STORE;
            end else if ((it.opcode == OP_MOVDQ_LD || it.opcode == OP_MOVDQ_ST)
                         && (it.prefix_opsize || it.prefix_rep)) begin
                kind = (it.opcode == OP_MOVDQ_LD) ? K_LOAD : K_STORE;
                aligned = it.prefix_opsize;
            end
        end

        // Alignment is checked before the fault flag; register forms ignore both.
        if (kind == K_NONE) begin
            res.status = ST_UNIMPL;
        end else if (!it.rm_is_register && aligned && (it.address_low & ALIGN_MASK) != 0) begin
            res.status = ST_UNALIGNED;
        end else if (!it.rm_is_register && it.memory_fault) begin
            res.status = ST_FAULT;
        end else begin
            if (it.rm_is_register) begin
                read_vec(it.rm_index, b_lo, b_hi);
            end else begin
                b_lo = it.load_low;
                b_hi = it.load_high;
            end
            read_vec(it.reg_index, a_lo, a_hi);
            case (kind)
                K_XOR: begin
                    write_vec(it.reg_index, a_lo ^ b_lo, a_hi ^ b_hi);
                end
                K_LOAD: begin
                    write_vec(it.reg_index, b_lo, b_hi);
                end
                default: begin
                    if (it.rm_is_register) begin
                        write_vec(it.rm_index, a_lo, a_hi);
                    end else begin
                        res.store_valid = 1'b1;
                        res.store_low = a_lo;
                        res.store_high = a_hi;
                    end
                end
            endcase
        end
        return res;
    endfunction

    function automatic t_item make_item(input logic map, input logic [7:0] op,
                                        input logic [2:0] pfx, input logic [3:0] rg,
                                        input logic [3:0] rm, input logic is_reg,
                                        input logic [3:0] addr, input logic [63:0] lo,
                                        input logic [63:0] hi, input logic fault);
        t_item it;
        it.two_byte_map = map;
        it.opcode = op;
        {it.prefix_opsize, it.prefix_rep, it.prefix_repne} = pfx;
        it.reg_index = rg;
        it.rm_index = rm;
        it.rm_is_register = is_reg;
        it.address_low = addr;
        it.load_low = lo;
        it.load_high = hi;
        it.memory_fault = fault;
        return it;
    endfunction

    // Present one item, hold it until accepted, then record what it must return.
    task automatic send_item(input t_item it);
        int gap;
        gap = tx_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_two_byte_map <= it.two_byte_map;
        i_opcode <= it.opcode;
        i_prefix_opsize <= it.prefix_opsize;
        i_prefix_rep <= it.prefix_rep;
        i_prefix_repne <= it.prefix_repne;
        i_reg_index <= it.reg_index;
        i_rm_index <= it.rm_index;
        i_rm_is_register <= it.rm_is_register;
        i_address_low <= it.address_low;
        i_load_low <= it.load_low;
        i_load_high <= it.load_high;
        i_memory_fault <= it.memory_fault;
        do @(posedge i_clk); while (full);
        retire_q.push_back(execute_instr(it));
        items_sent++;
    endtask

    // XOR forms: register and memory operands, ignored prefixes, self-clear.
    task automatic test_xor_forms();
        send_item(make_item(1, OP_MOVUPS_LD, PFX_NONE, 0, 0, 0, 4'hF, '1, '1, 0));
        send_item(make_item(1, OP_MOVAPS_LD, PFX_NONE, 15, 0, 0, 0, rand64(), rand64(), 0));
        send_item(make_item(1, OP_XORPS, PFX_ALL, 0, 15, 1, 4'hF, '0, '0, 1));
        send_item(make_item(1, OP_PXOR, PFX_66, 15, 2, 0, 7, rand64(), rand64(), 0));
        send_item(make_item(1, OP_PXOR, PFX_NONE, 15, 0, 1, 0, '0, '0, 0));
        send_item(make_item(1, OP_XORPS, PFX_NONE, 0, 0, 0, 3, rand64(), rand64(), 1));
        send_item(make_item(1, OP_XORPS, PFX_F2, 4, 4, 1, 0, '0, '0, 0));
    endtask

    // Move forms: loads, stores, alignment and fault handling.
    task automatic test_move_forms();
        send_item(make_item(1, OP_MOVAPS_ST, PFX_NONE, 15, 0, 0, 0, '0, '0, 0));
        send_item(make_item(1, OP_MOVAPS_ST, PFX_F3, 15, 0, 0, 8, '0, '0, 0));
        send_item(make_item(1, OP_MOVAPS_LD, PFX_NONE, 1, 0, 0, 0, '1, '1, 1));
        send_item(make_item(1, OP_MOVAPS_LD, PFX_NONE, 1, 0, 0, 1, '1, '1, 1));
        send_item(make_item(1, OP_MOVUPS_ST, PFX_NONE, 0, 0, 0, 3, '0, '0, 0));
        send_item(make_item(1, OP_MOVDQ_LD, PFX_66, 5, 0, 0, 0, rand64(), rand64(), 0));
        send_item(make_item(1, OP_MOVDQ_LD, PFX_F3, 6, 0, 0, 9, rand64(), rand64(), 0));
        send_item(make_item(1, OP_MOVDQ_ST, PFX_66 | PFX_F3, 5, 0, 0, 4, '0, '0, 0));
        send_item(make_item(1, OP_MOVDQ_ST, PFX_F3, 5, 0, 0, 1, '0, '0, 0));
        send_item(make_item(1, OP_MOVAPS_ST, PFX_NONE, 0, 3, 1, 5, '0, '0, 1));
        send_item(make_item(1, OP_MOVDQ_ST, PFX_66, 6, 10, 1, 2, '0, '0, 0));
        send_item(make_item(1, OP_MOVUPS_ST, PFX_NONE, 10, 0, 0, 0, '0, '0, 0));
        send_item(make_item(1, OP_MOVDQ_ST, PFX_F3, 3, 0, 0, 0, '0, '0, 0));
    endtask

    // Encodings that must come back unimplemented and change nothing.
    task automatic test_decode_rejects();
        send_item(make_item(1, OP_MOVUPS_ST, PFX_F3, 0, 0, 0, 0, '0, '0, 0));
        send_item(make_item(1, OP_MOVDQ_LD, PFX_NONE, 0, 0, 1, 0, '0, '0, 0));
        send_item(make_item(1, OP_MOVDQ_LD, PFX_F2, 0, 0, 0, 0, '1, '1, 0));
        send_item(make_item(0, OP_XORPS, PFX_NONE, 0, 0, 1, 0, '0, '0, 0));
        send_item(make_item(1, 8'hFF, PFX_ALL, 0, 0, 0, 0, '0, '0, 0));
        send_item(make_item(1, 8'h00, PFX_NONE, 15, 15, 1, 4'hF, '0, '0, 1));
    endtask

    // Random instructions: mostly valid encodings with random operands, some noise.
    task automatic run_random(input int count);
        t_item it;
        int    form;
        for (int n = 0; n < count; n++) begin
            form = $urandom_range(0, 11);
            it.two_byte_map = 1'b1;
            {it.prefix_opsize, it.prefix_rep, it.prefix_repne} = 3'($urandom_range(0, 7));
            case (form)
                0:  it.opcode = OP_XORPS;
                1:  begin it.opcode = OP_PXOR; it.prefix_opsize = 1'b1; end
                2:  it.opcode = OP_MOVAPS_LD;
                3:  it.opcode = OP_MOVAPS_ST;
                4:  begin it.opcode = OP_MOVUPS_LD; {it.prefix_opsize, it.prefix_rep,
                          it.prefix_repne} = PFX_NONE; end
                5:  begin it.opcode = OP_MOVUPS_ST; {it.prefix_opsize, it.prefix_rep,
                          it.prefix_repne} = PFX_NONE; end
                6:  begin it.opcode = OP_MOVDQ_LD; it.prefix_opsize = 1'b1; end
                7:  begin it.opcode = OP_MOVDQ_LD; it.prefix_rep = 1'b1; end
                8:  begin it.opcode = OP_MOVDQ_ST; it.prefix_opsize = 1'b1; end
                9:  begin it.opcode = OP_MOVDQ_ST; it.prefix_rep = 1'b1; end
                default: begin
                    it.two_byte_map = 1'($urandom_range(0, 1));
                    it.opcode = 8'($urandom_range(0, 255));
                end
            endcase
            // A narrow index range now and then builds dependency chains.
            if ($urandom_range(0, 9) < 3) begin
                it.reg_index = 4'($urandom_range(0, 3));
                it.rm_index = 4'($urandom_range(0, 3));
            end else begin
                it.reg_index = 4'($urandom_range(0, 15));
                it.rm_index = 4'($urandom_range(0, 15));
            end
            it.rm_is_register = 1'($urandom_range(0, 1));
            it.address_low = ($urandom_range(0, 9) < 7) ? 4'h0 : 4'($urandom_range(0, 15));
            it.load_low = rand64();
            it.load_high = rand64();
            it.memory_fault = ($urandom_range(0, 7) == 0);
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(500);
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(300);
    endtask

    task automatic test_receiver_stalls();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        run_random(300);
    endtask

    // Result side: random pop stalls, in-order comparison and the watchdog.
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        logic    bad;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                status_count[o_status]++;
                if (o_store_valid) stores_seen++;
                if (retire_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: status %0d store_valid %0b",
                                 o_status, o_store_valid);
                end else begin
                    exp_r = retire_q.pop_front();
                    bad = (exp_r.status != t_status'(o_status))
                        || (exp_r.store_valid != o_store_valid)
                        || (exp_r.store_low != o_store_low)
                        || (exp_r.store_high != o_store_high);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch on result %0d: status exp %0d got %0d,",
                                     results_seen, exp_r.status, o_status);
                            $display("  store_valid exp %0b got %0b, low exp %h got %h,",
                                     exp_r.store_valid, o_store_valid,
                                     exp_r.store_low, o_store_low);
                            $display("  high exp %h got %h", exp_r.store_high, o_store_high);
                        end
                    end
                end
            end

            // Count cycles in which no item moves on either side.
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("watchdog: nothing accepted for %0d cycles, %0d results owed",
                         QUIET_LIMIT, retire_q.size());
                $display("status: fail");
                $finish;
            end

            // Pop stays high between stalls of random length.
            pop <= (rx_stall == 0);
            if (rx_stall != 0) begin
                rx_stall--;
            end else if (rx_idle_on) begin
                rx_stall = idle_len();
            end
        end
    end

    initial begin
        for (int r = 0; r < NUM_VECTOR_REGS; r++) begin
            arch_lo[r] = '0;
            arch_hi[r] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        test_xor_forms();
        tx_idle_on = 1'b1;
        test_move_forms();
        test_decode_rejects();
        test_random_traffic();
        test_back_to_back();
        test_receiver_stalls();

        // The last item was taken at this edge; stop pushing before the next one.
        push <= 1'b0;
        while (retire_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d instructions, checked %0d results, %0d of them stores.",
                 items_sent, results_seen, stores_seen);
        $display("Status mix: %0d ok, %0d unimplemented, %0d unaligned, %0d faulted.",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        if (mismatches == 0 && retire_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
